// File: rtl/core/sscs_pkg.sv
// shared types and constants of the stick calibration sequencer
`default_nettype none

package sscs_pkg;

   // fixed field widths
   localparam int SAMPLE_W     = 12;
   localparam int RANGE_W      = 16;
   localparam int TIMEOUT_W    = 16;
   localparam int CHANNELS_MAX = 4;

   // parameter defaults
   localparam int DEF_CHANNELS    = 4;
   localparam int DEF_SAMPLE_BITS = 12;

   // reset values
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET   = 16'd15000;
   localparam logic [RANGE_W-1:0]   RANGE_MIN_RESET = 16'hFFFF;
   localparam logic [RANGE_W-1:0]   RANGE_MAX_RESET = 16'h0000;
   localparam logic [RANGE_W-1:0]   ELAPSED_MAX     = 16'hFFFF;

   // command codes
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_ENTER = 2'd1;
   localparam logic [1:0] CMD_EXIT  = 2'd2;

   // register indexes
   localparam logic REG_TIMEOUT = 1'b0;

   // calibration phases
   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_CENTER  = 3'd1,
      PH_SWEEP   = 3'd2,
      PH_SUCCESS = 3'd3,
      PH_TIMEOUT = 3'd4
   } phase_type;

   // one accepted request transaction
   typedef struct packed {
      logic [1:0]                                cmd;
      logic [CHANNELS_MAX-1:0][SAMPLE_W-1:0]     samples;
      logic [1:0]                                read_channel;
   } item_type;

   // one response transaction
   typedef struct packed {
      phase_type             phase;
      logic                  link_enabled;
      logic                  leave_request;
      logic [SAMPLE_W-1:0]   zero_value;
      logic [RANGE_W-1:0]    min_value;
      logic [RANGE_W-1:0]    max_value;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/core/sscs_csr.sv
// configuration register file with apb-style access
`default_nettype none

module sscs_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [2:0]                        csr_paddr,
   input  wire logic [31:0]                       csr_pwdata,
   output logic      [31:0]                       csr_prdata,
   output logic                                   csr_pready,
   output logic      [sscs_pkg::TIMEOUT_W-1:0]    timeout_ticks
);

   logic [sscs_pkg::TIMEOUT_W-1:0] timeout_ff;
   logic [sscs_pkg::TIMEOUT_W-1:0] timeout_in;
   logic                           wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // register write decode
   always_comb begin
      timeout_in = timeout_ff;
      if (wr_en && (csr_paddr[2] == sscs_pkg::REG_TIMEOUT)) begin
         timeout_in = csr_pwdata[sscs_pkg::TIMEOUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= sscs_pkg::TIMEOUT_RESET;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   // read back
   always_comb begin
      csr_prdata = 32'd0;
      if (csr_paddr[2] == sscs_pkg::REG_TIMEOUT) begin
         csr_prdata = {{(32-sscs_pkg::TIMEOUT_W){1'b0}}, timeout_ff};
      end
   end

   assign timeout_ticks = timeout_ff;

endmodule

`default_nettype wire

// File: rtl/core/sscs_core.sv
// calibration state registers and their single-pass update
`default_nettype none

module sscs_core #(
   parameter int CHANNELS    = sscs_pkg::DEF_CHANNELS,
   parameter int SAMPLE_BITS = sscs_pkg::DEF_SAMPLE_BITS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            step_en,
   input  wire sscs_pkg::item_type              item,
   input  wire logic [sscs_pkg::TIMEOUT_W-1:0]  timeout_ticks,
   output sscs_pkg::result_type                 result
);

   localparam int KEEP_BITS = (SAMPLE_BITS < sscs_pkg::SAMPLE_W) ? SAMPLE_BITS
                                                                 : sscs_pkg::SAMPLE_W;
   localparam logic [sscs_pkg::SAMPLE_W-1:0] SAMPLE_MASK =
      sscs_pkg::SAMPLE_W'((32'd1 << KEEP_BITS) - 32'd1);

   sscs_pkg::phase_type             phase_ff, phase_in;
   logic                            link_ff, link_in;
   logic [sscs_pkg::RANGE_W-1:0]    elapsed_ff, elapsed_in;
   logic [sscs_pkg::RANGE_W-1:0]    elapsed_inc;
   logic                            tick_sweep;
   logic                            timed_out;
   logic [sscs_pkg::SAMPLE_W-1:0]   zero_ff [CHANNELS];
   logic [sscs_pkg::SAMPLE_W-1:0]   zero_in [CHANNELS];
   logic [sscs_pkg::RANGE_W-1:0]    min_ff  [CHANNELS];
   logic [sscs_pkg::RANGE_W-1:0]    min_in  [CHANNELS];
   logic [sscs_pkg::RANGE_W-1:0]    max_ff  [CHANNELS];
   logic [sscs_pkg::RANGE_W-1:0]    max_in  [CHANNELS];
   logic [sscs_pkg::RANGE_W-1:0]    sample  [CHANNELS];

   // masked samples, widened to range width
   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         sample[i] = {{(sscs_pkg::RANGE_W-sscs_pkg::SAMPLE_W){1'b0}},
                      item.samples[i] & SAMPLE_MASK};
      end
   end

   // saturating sweep counter and timeout check
   assign elapsed_inc = (elapsed_ff < sscs_pkg::ELAPSED_MAX) ? (elapsed_ff + 16'd1)
                                                              : elapsed_ff;
   assign tick_sweep  = (item.cmd == sscs_pkg::CMD_TICK) && (phase_ff == sscs_pkg::PH_SWEEP);
   assign timed_out   = tick_sweep && (elapsed_inc > timeout_ticks);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      case (item.cmd)
         sscs_pkg::CMD_TICK: begin
            if (timed_out) begin
               phase_in = sscs_pkg::PH_TIMEOUT;
            end
         end
         sscs_pkg::CMD_ENTER: begin
            case (phase_ff)
               sscs_pkg::PH_CENTER:  phase_in = sscs_pkg::PH_SWEEP;
               sscs_pkg::PH_SWEEP:   phase_in = sscs_pkg::PH_SUCCESS;
               sscs_pkg::PH_SUCCESS: phase_in = sscs_pkg::PH_IDLE;
               sscs_pkg::PH_TIMEOUT: phase_in = sscs_pkg::PH_IDLE;
               default:              phase_in = sscs_pkg::PH_CENTER;
            endcase
         end
         sscs_pkg::CMD_EXIT: begin
            phase_in = sscs_pkg::PH_IDLE;
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   // link flag, counter and per-channel calibration data
   always_comb begin
      link_in    = link_ff;
      elapsed_in = elapsed_ff;
      for (int i = 0; i < CHANNELS; i++) begin
         zero_in[i] = zero_ff[i];
         min_in[i]  = min_ff[i];
         max_in[i]  = max_ff[i];
      end
      case (item.cmd)
         sscs_pkg::CMD_TICK: begin
            if (tick_sweep) begin
               elapsed_in = elapsed_inc;
               if (timed_out) begin
                  link_in = 1'b1;
               end else begin
                  for (int i = 0; i < CHANNELS; i++) begin
                     if (sample[i] > max_ff[i]) begin
                        max_in[i] = sample[i];
                     end else if (sample[i] < min_ff[i]) begin
                        min_in[i] = sample[i];
                     end
                  end
               end
            end
         end
         sscs_pkg::CMD_ENTER: begin
            case (phase_ff)
               sscs_pkg::PH_CENTER: begin
                  for (int i = 0; i < CHANNELS; i++) begin
                     zero_in[i] = sample[i][sscs_pkg::SAMPLE_W-1:0];
                  end
                  elapsed_in = '0;
               end
               sscs_pkg::PH_SWEEP: begin
                  link_in = 1'b1;
               end
               sscs_pkg::PH_SUCCESS: begin
                  link_in = link_ff;
               end
               sscs_pkg::PH_TIMEOUT: begin
                  link_in = link_ff;
               end
               default: begin
                  link_in = 1'b0;
               end
            endcase
         end
         sscs_pkg::CMD_EXIT: begin
            if ((phase_ff == sscs_pkg::PH_CENTER) || (phase_ff == sscs_pkg::PH_SWEEP)) begin
               link_in = 1'b1;
            end
            for (int i = 0; i < CHANNELS; i++) begin
               min_in[i] = sscs_pkg::RANGE_MIN_RESET;
               max_in[i] = sscs_pkg::RANGE_MAX_RESET;
            end
         end
         default: begin
            link_in = link_ff;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= sscs_pkg::PH_IDLE;
         link_ff    <= 1'b1;
         elapsed_ff <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            zero_ff[i] <= '0;
            min_ff[i]  <= sscs_pkg::RANGE_MIN_RESET;
            max_ff[i]  <= sscs_pkg::RANGE_MAX_RESET;
         end
      end else if (step_en) begin
         phase_ff   <= phase_in;
         link_ff    <= link_in;
         elapsed_ff <= elapsed_in;
         for (int i = 0; i < CHANNELS; i++) begin
            zero_ff[i] <= zero_in[i];
            min_ff[i]  <= min_in[i];
            max_ff[i]  <= max_in[i];
         end
      end
   end

   // result from the updated state, channel picked by read_channel
   always_comb begin
      result.phase         = phase_in;
      result.link_enabled  = link_in;
      result.leave_request = (item.cmd == sscs_pkg::CMD_EXIT);
      result.zero_value    = '0;
      result.min_value     = sscs_pkg::RANGE_MIN_RESET;
      result.max_value     = sscs_pkg::RANGE_MAX_RESET;
      for (int i = 0; i < CHANNELS; i++) begin
         if (item.read_channel == 2'(i)) begin
            result.zero_value = zero_in[i];
            result.min_value  = min_in[i];
            result.max_value  = max_in[i];
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/stick_calibration_sequencer_unit.sv
// top level of the stick calibration sequencer
//
//   channel | ports  | handshake         | payload
//   --------+--------+-------------------+------------------------------------------
//   request | req_*  | valid / ready     | cmd, sample_a..d, read_channel
//   response| rsp_*  | valid / ready     | phase, link_enabled, leave_request, values
//   config  | csr_*  | apb, pready high  | timeout_ticks at byte address 0
//
// one transaction per cycle sustained while rsp_ready stays high; a taken request is
// captured in the input register, and its response is valid once it is in the response
// register: the update runs between the input register and the response register
// reset is synchronous: phase to not started, link flag set, counter and data to
// their reset values
// a stalled response holds; the input register still takes one request meanwhile
`default_nettype none

module stick_calibration_sequencer_unit #(
   parameter int CHANNELS    = sscs_pkg::DEF_CHANNELS,
   parameter int SAMPLE_BITS = sscs_pkg::DEF_SAMPLE_BITS
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [1:0]   req_cmd,
   input  wire logic [11:0]  req_sample_a,
   input  wire logic [11:0]  req_sample_b,
   input  wire logic [11:0]  req_sample_c,
   input  wire logic [11:0]  req_sample_d,
   input  wire logic [1:0]   req_read_channel,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [2:0]        rsp_phase,
   output logic              rsp_link_enabled,
   output logic              rsp_leave_request,
   output logic [11:0]       rsp_zero_value,
   output logic [15:0]       rsp_min_value,
   output logic [15:0]       rsp_max_value,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [2:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   logic                              in_valid_ff, in_valid_in;
   sscs_pkg::item_type                in_item_ff;
   logic                              out_valid_ff, out_valid_in;
   sscs_pkg::result_type              out_result_ff;
   sscs_pkg::result_type              core_result;
   logic [sscs_pkg::TIMEOUT_W-1:0]    timeout_ticks;
   logic                              req_fire;
   logic                              advance;

   // configuration registers
   sscs_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .timeout_ticks (timeout_ticks)
   );

   // handshake control
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.cmd          <= req_cmd;
         in_item_ff.samples      <= {req_sample_d, req_sample_c, req_sample_b, req_sample_a};
         in_item_ff.read_channel <= req_read_channel;
      end
   end

   // state update
   sscs_core #(
      .CHANNELS    (CHANNELS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .step_en       (advance),
      .item          (in_item_ff),
      .timeout_ticks (timeout_ticks),
      .result        (core_result)
   );

   // response register
   always_ff @(posedge clock) begin
      if (advance) begin
         out_result_ff <= core_result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_phase         = 3'(out_result_ff.phase);
   assign rsp_link_enabled  = out_result_ff.link_enabled;
   assign rsp_leave_request = out_result_ff.leave_request;
   assign rsp_zero_value    = out_result_ff.zero_value;
   assign rsp_min_value     = out_result_ff.min_value;
   assign rsp_max_value     = out_result_ff.max_value;

endmodule

`default_nettype wire

// File: rtl/core/sscs_checker.sv
// port-level checker of the stick calibration sequencer and its bind
`default_nettype none

module sscs_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         rsp_valid,
   input wire logic         rsp_ready,
   input wire logic [2:0]   rsp_phase,
   input wire logic         rsp_link_enabled,
   input wire logic         rsp_leave_request,
   input wire logic [15:0]  rsp_min_value,
   input wire logic [15:0]  rsp_max_value
);

   // a stalled response stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped while stalled");

   // exit always lands in not started
   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_leave_request) |-> (rsp_phase == sscs_pkg::PH_IDLE))
      else $error("exit transaction not in not-started phase");

   // exit clears the observed range
   a_leave_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_leave_request) |->
         ((rsp_min_value == sscs_pkg::RANGE_MIN_RESET) &&
          (rsp_max_value == sscs_pkg::RANGE_MAX_RESET)))
      else $error("exit transaction left range uncleared");

   // link off exactly while calibrating
   a_link_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_link_enabled ==
                     !((rsp_phase == sscs_pkg::PH_CENTER) ||
                       (rsp_phase == sscs_pkg::PH_SWEEP))))
      else $error("link flag disagrees with phase");

endmodule

bind stick_calibration_sequencer_unit sscs_checker u_sscs_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_phase         (rsp_phase),
   .rsp_link_enabled  (rsp_link_enabled),
   .rsp_leave_request (rsp_leave_request),
   .rsp_min_value     (rsp_min_value),
   .rsp_max_value     (rsp_max_value)
);

`default_nettype wire

// File: bench/stick_calibration_sequencer_unit_test.sv
// testbench of the stick calibration sequencer: queued request traffic, predicted readouts
module stick_calibration_sequencer_unit_test;
   import sscs_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int PHASES      = 5;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_cmd = '0;
   logic [11:0] req_sample_a = '0;
   logic [11:0] req_sample_b = '0;
   logic [11:0] req_sample_c = '0;
   logic [11:0] req_sample_d = '0;
   logic [1:0]  req_read_channel = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_phase;
   logic        rsp_link_enabled;
   logic        rsp_leave_request;
   logic [11:0] rsp_zero_value;
   logic [15:0] rsp_min_value;
   logic [15:0] rsp_max_value;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   stick_calibration_sequencer_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_sample_a      (req_sample_a),
      .req_sample_b      (req_sample_b),
      .req_sample_c      (req_sample_c),
      .req_sample_d      (req_sample_d),
      .req_read_channel  (req_read_channel),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_phase         (rsp_phase),
      .rsp_link_enabled  (rsp_link_enabled),
      .rsp_leave_request (rsp_leave_request),
      .rsp_zero_value    (rsp_zero_value),
      .rsp_min_value     (rsp_min_value),
      .rsp_max_value     (rsp_max_value),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   // clock, period 8
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // request queue, expected readouts and bookkeeping
   item_type   pending_requests[$];
   result_type expected_readouts[$];
   int         requests_queued = 0;
   int         requests_taken = 0;
   int         readout_errors = 0;
   int         send_idle_pct = 0;
   int         stall_pct = 0;
   int         gen_timeout = int'(TIMEOUT_RESET);

   // predicted sequencer state
   phase_type           cal_phase;
   logic                cal_link;
   logic [15:0]         cal_elapsed;
   logic [15:0]         cal_timeout;
   logic [SAMPLE_W-1:0] cal_zero[CHANNELS_MAX];
   logic [RANGE_W-1:0]  cal_min[CHANNELS_MAX];
   logic [RANGE_W-1:0]  cal_max[CHANNELS_MAX];

   function automatic void clear_cal_ranges();
      int ch;
      for (ch = 0; ch < CHANNELS_MAX; ch++) begin
         cal_min[ch] = RANGE_MIN_RESET;
         cal_max[ch] = RANGE_MAX_RESET;
      end
   endfunction

   // advance the predicted state by one request and return the readout it causes
   function automatic result_type calibrate_step(input item_type it);
      result_type r;
      int ch;
      r.leave_request = 1'b0;
      case (it.cmd)
         CMD_TICK: begin
            if (cal_phase == PH_SWEEP) begin
               if (cal_elapsed != ELAPSED_MAX) cal_elapsed = cal_elapsed + 16'd1;
               if (cal_elapsed > cal_timeout) begin
                  cal_phase = PH_TIMEOUT;
                  cal_link  = 1'b1;
               end else begin
                  // a channel raises its max, otherwise may lower its min
                  for (ch = 0; ch < CHANNELS_MAX; ch++) begin
                     if (RANGE_W'(it.samples[ch]) > cal_max[ch])
                        cal_max[ch] = RANGE_W'(it.samples[ch]);
                     else if (RANGE_W'(it.samples[ch]) < cal_min[ch])
                        cal_min[ch] = RANGE_W'(it.samples[ch]);
                  end
               end
            end
         end
         CMD_ENTER: begin
            case (cal_phase)
               PH_CENTER: begin
                  for (ch = 0; ch < CHANNELS_MAX; ch++) cal_zero[ch] = it.samples[ch];
                  cal_elapsed = '0;
                  cal_phase   = PH_SWEEP;
               end
               PH_SWEEP: begin
                  cal_phase = PH_SUCCESS;
                  cal_link  = 1'b1;
               end
               PH_SUCCESS, PH_TIMEOUT: cal_phase = PH_IDLE;
               default: begin
                  cal_phase = PH_CENTER;
                  cal_link  = 1'b0;
               end
            endcase
         end
         CMD_EXIT: begin
            if (cal_phase == PH_CENTER || cal_phase == PH_SWEEP) cal_link = 1'b1;
            cal_phase = PH_IDLE;
            clear_cal_ranges();
            r.leave_request = 1'b1;
         end
         default: ;
      endcase
      r.phase        = cal_phase;
      r.link_enabled = cal_link;
      r.zero_value   = cal_zero[it.read_channel];
      r.min_value    = cal_min[it.read_channel];
      r.max_value    = cal_max[it.read_channel];
      return r;
   endfunction

   // request driver
   always @(posedge clock) begin : drive_requests
      item_type it;
      item_type next;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            it.cmd          = req_cmd;
            it.samples[0]   = req_sample_a;
            it.samples[1]   = req_sample_b;
            it.samples[2]   = req_sample_c;
            it.samples[3]   = req_sample_d;
            it.read_channel = req_read_channel;
            expected_readouts.push_back(calibrate_step(it));
            requests_taken++;
         end
         // a pending transaction holds until it is taken
         if (!req_valid || req_ready) begin
            if (pending_requests.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               next = pending_requests.pop_front();
               req_valid        <= 1'b1;
               req_cmd          <= next.cmd;
               req_sample_a     <= next.samples[0];
               req_sample_b     <= next.samples[1];
               req_sample_c     <= next.samples[2];
               req_sample_d     <= next.samples[3];
               req_read_channel <= next.read_channel;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // readout monitor and receiver stalls
   always @(posedge clock) begin : check_readouts
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_readouts.size() == 0) begin
            readout_errors++;
            if (readout_errors <= 10)
               $display("unexpected readout transaction: phase %0d", rsp_phase);
         end else begin
            want = expected_readouts.pop_front();
            if (rsp_phase !== want.phase || rsp_link_enabled !== want.link_enabled ||
                rsp_leave_request !== want.leave_request ||
                rsp_zero_value !== want.zero_value ||
                rsp_min_value !== want.min_value || rsp_max_value !== want.max_value) begin
               readout_errors++;
               if (readout_errors <= 10) begin
                  $write("readout mismatch (expected/actual): phase %0d/%0d link %0b/%0b",
                         want.phase, rsp_phase, want.link_enabled, rsp_link_enabled);
                  $display(" leave %0b/%0b zero %0d/%0d min %0d/%0d max %0d/%0d",
                           want.leave_request, rsp_leave_request, want.zero_value,
                           rsp_zero_value, want.min_value, rsp_min_value,
                           want.max_value, rsp_max_value);
               end
            end
         end
      end
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // watchdog on cycles without any accepted transaction
   always @(posedge clock) begin : watchdog
      int quiet;
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable && csr_pwrite && csr_pready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // stimulus helpers
   function automatic logic [11:0] rand_sample();
      case ($urandom_range(0, 7))
         0: return 12'd0;
         1: return 12'hFFF;
         default: return 12'($urandom_range(0, 4095));
      endcase
   endfunction

   task automatic add_request(input logic [1:0] cmd, input logic [11:0] a, input logic [11:0] b,
                              input logic [11:0] c, input logic [11:0] d,
                              input logic [1:0] sel);
      item_type it;
      it.cmd          = cmd;
      it.samples[0]   = a;
      it.samples[1]   = b;
      it.samples[2]   = c;
      it.samples[3]   = d;
      it.read_channel = sel;
      pending_requests.push_back(it);
      requests_queued++;
   endtask

   task automatic add_random(input logic [1:0] cmd);
      add_request(cmd, rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                  2'($urandom_range(0, 3)));
   endtask

   // one calibration pass: center, sweep of ticks, then success, timeout or exit
   task automatic add_calibration_run();
      int ticks;
      int k;
      if ($urandom_range(0, 3) == 0) add_random(CMD_EXIT);
      add_random(CMD_ENTER);
      add_random(CMD_ENTER);
      ticks = $urandom_range(0, (gen_timeout + 2 > 40) ? 40 : gen_timeout + 2);
      for (k = 0; k < ticks; k++) add_random(CMD_TICK);
      if ($urandom_range(0, 2) == 0) begin
         add_random(CMD_EXIT);
      end else if (ticks > gen_timeout) begin
         add_random(CMD_ENTER);
      end else begin
         add_random(CMD_ENTER);
         add_random(CMD_ENTER);
      end
   endtask

   task automatic add_random_traffic(input int target);
      int start;
      start = requests_queued;
      while (requests_queued - start < target) begin
         if ($urandom_range(0, 9) == 0) add_random(2'($urandom_range(0, 3)));
         else add_calibration_run();
      end
   endtask

   task automatic add_directed();
      add_request(CMD_TICK, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 2'd0);
      add_request(2'd3, 12'd0, 12'd0, 12'd0, 12'd0, 2'd1);
      add_request(CMD_EXIT, 12'd0, 12'd0, 12'd0, 12'd0, 2'd2);
      add_request(CMD_ENTER, 12'd1, 12'd2, 12'd3, 12'd4, 2'd3);
      add_request(CMD_TICK, 12'hFFF, 12'd0, 12'hFFF, 12'd0, 2'd0);
      // exit from center brings the link back
      add_request(CMD_EXIT, 12'd0, 12'd0, 12'd0, 12'd0, 2'd0);
      add_request(CMD_ENTER, 12'd0, 12'd0, 12'd0, 12'd0, 2'd0);
      add_request(CMD_ENTER, 12'd0, 12'hFFF, 12'h555, 12'hAAA, 2'd1);
      // sweep: all zero lowers minima only, all ones raises maxima
      add_request(CMD_TICK, 12'd0, 12'd0, 12'd0, 12'd0, 2'd0);
      add_request(CMD_TICK, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 2'd1);
      add_request(CMD_TICK, 12'h800, 12'h7FF, 12'h001, 12'hFFE, 2'd2);
      add_request(2'd3, 12'h123, 12'h456, 12'h789, 12'hABC, 2'd3);
      add_request(CMD_ENTER, 12'd0, 12'd0, 12'd0, 12'd0, 2'd2);
      add_request(CMD_TICK, 12'd5, 12'd5, 12'd5, 12'd5, 2'd3);
      add_request(CMD_ENTER, 12'd0, 12'd0, 12'd0, 12'd0, 2'd3);
      // exit in the middle of a sweep clears ranges, keeps zero points
      add_request(CMD_ENTER, 12'd0, 12'd0, 12'd0, 12'd0, 2'd0);
      add_request(CMD_ENTER, 12'hFFF, 12'h000, 12'hAAA, 12'h555, 2'd1);
      add_request(CMD_TICK, 12'h400, 12'h400, 12'h400, 12'h400, 2'd2);
      add_request(CMD_EXIT, 12'd0, 12'd0, 12'd0, 12'd0, 2'd1);
      // exit from success leaves the link enabled
      add_request(CMD_ENTER, 12'd0, 12'd0, 12'd0, 12'd0, 2'd0);
      add_request(CMD_ENTER, 12'd7, 12'd7, 12'd7, 12'd7, 2'd2);
      add_request(CMD_ENTER, 12'd0, 12'd0, 12'd0, 12'd0, 2'd3);
      add_request(CMD_EXIT, 12'd0, 12'd0, 12'd0, 12'd0, 2'd0);
   endtask

   task automatic write_timeout(input logic [15:0] value);
      @(posedge clock);
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr  <= {REG_TIMEOUT, 2'b00};
      csr_pwdata <= {16'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      cal_timeout = value;
      gen_timeout = int'(value);
   endtask

   task automatic wait_drained();
      while (requests_taken != requests_queued || expected_readouts.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // sequence of traffic phases
   initial begin : run_phases
      int p;
      int timeouts[PHASES];
      int idle_pcts[PHASES];
      int stall_pcts[PHASES];
      int counts[PHASES];
      timeouts   = '{15000, 1, 20, 65534, 7};
      idle_pcts  = '{0, 0, 86, 0, 24};
      stall_pcts = '{0, 0, 0, 86, 24};
      counts     = '{250, 150, 320, 320, 320};

      cal_phase   = PH_IDLE;
      cal_link    = 1'b1;
      cal_elapsed = '0;
      cal_timeout = TIMEOUT_RESET;
      for (p = 0; p < CHANNELS_MAX; p++) cal_zero[p] = '0;
      clear_cal_ranges();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (p = 0; p < PHASES; p++) begin
         if (p > 0) write_timeout(16'(timeouts[p]));
         send_idle_pct = idle_pcts[p];
         stall_pct     = stall_pcts[p];
         if (p == 0) add_directed();
         add_random_traffic(counts[p]);
         wait_drained();
      end

      repeat (8) @(posedge clock);
      readout_errors += expected_readouts.size();
      if (readout_errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
